// ----- sv/rtmc_pkg.sv -----
package rtmc_pkg;

  localparam int KEY_W = 32;
  localparam int OUT_W = 16;

  typedef struct packed {
    logic signed [KEY_W-1:0] sample_value;
    logic                    row_end;
    logic                    row_empty;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] first_mode_count;
    logic [OUT_W-1:0] second_mode_count;
    logic             table_overflow;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture the input transfer
    logic look;      // key compare and count read
    logic commit;    // count write-back, top-two update, row clear
    logic out_load;  // capture the result
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic emit;      // held item closes a row
  } dp_sts_t;

endpackage

// ----- sv/rtmc_ctrl.sv -----
module rtmc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  rtmc_pkg::dp_sts_t  sts,
  output rtmc_pkg::ctl_cmd_t cmd
);
  import rtmc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_busy;
  logic       upd_done;
  logic       in_acc;

  assign out_busy = out_valid_r && out_stall;
  // finish the update unless its result would land on a held result
  assign upd_done = (state_r == S_UPD) && !(sts.emit && out_busy);
  assign in_stall = !((state_r == S_IDLE) || upd_done);
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.load     = in_acc;
    cmd.look     = (state_r == S_LOOK);
    cmd.commit   = upd_done;
    cmd.out_load = upd_done && sts.emit;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_LOOK;
      end
      S_LOOK: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (upd_done) state_nxt = in_acc ? S_LOOK : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_look_then_upd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOOK |=> state_r == S_UPD)
    else $error("lookup not followed by update");

  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_busy)
    else $error("result overwrote a held result");

  a_accept_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (state_r == S_IDLE || state_r == S_UPD))
    else $error("transfer taken mid-lookup");

endmodule

// ----- sv/rtmc_dp.sv -----
module rtmc_dp #(
  parameter int MAX_DISTINCT = 64,
  parameter int COUNT_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rtmc_pkg::in_item_t  in_data,
  input  rtmc_pkg::ctl_cmd_t  cmd,
  output rtmc_pkg::dp_sts_t   sts,
  output rtmc_pkg::out_item_t out_data
);
  import rtmc_pkg::*;

  localparam int IDX_W = $clog2(MAX_DISTINCT);
  localparam int DT_W  = $clog2(MAX_DISTINCT + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  in_item_t                item_r;
  logic [KEY_W-1:0]        key_r [MAX_DISTINCT];
  logic [MAX_DISTINCT-1:0] valid_r;
  logic [COUNT_BITS-1:0]   count_mem [MAX_DISTINCT];
  logic [DT_W-1:0]         dt_r;
  logic [KEY_W-1:0]        best_key_r, run_key_r;
  logic [COUNT_BITS-1:0]   best_cnt_r, run_cnt_r;
  logic                    ovf_r;
  logic                    hit_r;
  logic [IDX_W-1:0]        hidx_r;
  logic [COUNT_BITS-1:0]   rd_cnt_r;
  out_item_t               out_r;

  logic                    hit;
  logic [IDX_W-1:0]        hidx;
  logic [KEY_W-1:0]        k;
  logic                    full;
  logic                    new_key;
  logic                    counted;
  logic [IDX_W-1:0]        wr_idx;
  logic [COUNT_BITS-1:0]   cval;
  logic [KEY_W-1:0]        best_key_nxt, run_key_nxt;
  logic [COUNT_BITS-1:0]   best_cnt_nxt, run_cnt_nxt;
  logic [DT_W-1:0]         dt_nxt;
  logic                    ovf_nxt;
  out_item_t               res;

  function automatic logic [OUT_W-1:0] clip_out(input logic [COUNT_BITS-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return (w > 32'h0000_FFFF) ? {OUT_W{1'b1}} : w[OUT_W-1:0];
  endfunction

  assign k = $unsigned(item_r.sample_value);

  // associative compare; live keys are unique so OR-encoding is exact
  always_comb begin
    hit  = 1'b0;
    hidx = '0;
    for (int i = 0; i < MAX_DISTINCT; i++) begin
      if (valid_r[i] && key_r[i] == k) begin
        hit  = 1'b1;
        hidx = hidx | IDX_W'(i);
      end
    end
  end

  always_comb begin
    full    = (dt_r == DT_W'(MAX_DISTINCT));
    new_key = !item_r.row_empty && !hit_r && !full;
    counted = !item_r.row_empty && (hit_r || !full);
    wr_idx  = hit_r ? hidx_r : dt_r[IDX_W-1:0];
    if (hit_r) begin
      cval = (rd_cnt_r == CNT_MAX) ? rd_cnt_r : rd_cnt_r + COUNT_BITS'(1);
    end else begin
      cval = COUNT_BITS'(1);
    end

    best_key_nxt = best_key_r;
    best_cnt_nxt = best_cnt_r;
    run_key_nxt  = run_key_r;
    run_cnt_nxt  = run_cnt_r;
    if (counted) begin
      if (best_cnt_r != '0 && k == best_key_r) begin
        best_cnt_nxt = cval;
      end else if (cval > best_cnt_r) begin
        run_key_nxt  = best_key_r;
        run_cnt_nxt  = best_cnt_r;
        best_key_nxt = k;
        best_cnt_nxt = cval;
      end else if (run_cnt_r != '0 && k == run_key_r) begin
        run_cnt_nxt = cval;
      end else if (cval > run_cnt_r) begin
        run_key_nxt = k;
        run_cnt_nxt = cval;
      end
    end

    dt_nxt  = dt_r + {{(DT_W-1){1'b0}}, new_key};
    ovf_nxt = ovf_r || (!item_r.row_empty && !hit_r && full);

    if (item_r.row_empty) begin
      res = '0;
    end else begin
      res.table_overflow = ovf_nxt;
      if (dt_nxt >= DT_W'(2)) begin
        res.first_mode_count  = clip_out(best_cnt_nxt);
        res.second_mode_count = clip_out(run_cnt_nxt);
      end else begin
        res.first_mode_count  = '0;
        res.second_mode_count = '0;
      end
    end
  end

  assign sts.emit = item_r.row_end || item_r.row_empty;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (cmd.look) begin
      hit_r    <= hit;
      hidx_r   <= hidx;
      rd_cnt_r <= count_mem[hidx];
    end
    if (cmd.commit && new_key) key_r[dt_r[IDX_W-1:0]] <= k;
    if (cmd.out_load) out_r <= res;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && counted) count_mem[wr_idx] <= cval;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      dt_r       <= '0;
      best_key_r <= '0;
      best_cnt_r <= '0;
      run_key_r  <= '0;
      run_cnt_r  <= '0;
      ovf_r      <= 1'b0;
    end else if (cmd.commit) begin
      if (sts.emit) begin
        // drop the row's histogram
        valid_r    <= '0;
        dt_r       <= '0;
        best_key_r <= '0;
        best_cnt_r <= '0;
        run_key_r  <= '0;
        run_cnt_r  <= '0;
        ovf_r      <= 1'b0;
      end else begin
        if (new_key) valid_r[dt_r[IDX_W-1:0]] <= 1'b1;
        dt_r       <= dt_nxt;
        best_key_r <= best_key_nxt;
        best_cnt_r <= best_cnt_nxt;
        run_key_r  <= run_key_nxt;
        run_cnt_r  <= run_cnt_nxt;
        ovf_r      <= ovf_nxt;
      end
    end
  end

endmodule

// ----- sv/row_top_two_mode_counter.sv -----
// Channel  Direction  Ports                          Payload
// input    in         in_valid, in_stall, in_data    sample_value, row_end, row_empty
// result   out        out_valid, out_stall, out_data first/second_mode_count, table_overflow
//
// Each item goes through a compare against all stored keys (S_LOOK), then a
// read-modify-write of the count memory with the top-two update (S_UPD).
// A row-closing item shows its result on out_valid in the cycle after its update.
// rst_n clears the histogram at once; no clearing pass is needed.
// A held result blocks only the next row-closing item, not row values.
module row_top_two_mode_counter #(
  parameter int MAX_DISTINCT = 64,
  parameter int COUNT_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rtmc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rtmc_pkg::out_item_t out_data
);
  import rtmc_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  rtmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rtmc_dp #(
    .MAX_DISTINCT (MAX_DISTINCT),
    .COUNT_BITS   (COUNT_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// ----- tb/tb_row_top_two_mode_counter.sv -----
module tb_row_top_two_mode_counter;
  timeunit 1ns;
  timeprecision 1ps;

  import rtmc_pkg::*;

  localparam int MAX_DISTINCT = 64;
  localparam int COUNT_BITS   = 16;
  localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;
  localparam int IDLE_PCT     = 13;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  row_top_two_mode_counter #(
    .MAX_DISTINCT(MAX_DISTINCT),
    .COUNT_BITS  (COUNT_BITS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Histogram mirror
  logic [KEY_W-1:0]      hist_key [MAX_DISTINCT];
  bit                    hist_used[MAX_DISTINCT];
  logic [COUNT_BITS-1:0] hist_cnt [MAX_DISTINCT];
  logic [KEY_W-1:0]      lead_key, second_key;
  logic [COUNT_BITS-1:0] lead_cnt, second_cnt;
  int unsigned           distinct_n;
  bit                    dropped_key;

  in_item_t  pending_q[$];
  out_item_t mode_expect_q[$];
  out_item_t mode_want;

  int unsigned queued_n     = 0;
  int unsigned accepted_n   = 0;
  int unsigned rows_checked = 0;
  int unsigned overflow_n   = 0;
  int unsigned mismatch_n   = 0;

  // no idling on either side during this stretch of transfers
  wire no_gaps = (accepted_n >= 300) && (accepted_n < 450);

  function automatic void clear_hist();
    for (int i = 0; i < MAX_DISTINCT; i++) begin
      hist_used[i] = 1'b0;
      hist_key[i]  = '0;
      hist_cnt[i]  = '0;
    end
    lead_key    = '0;
    lead_cnt    = '0;
    second_key  = '0;
    second_cnt  = '0;
    distinct_n  = 0;
    dropped_key = 1'b0;
  endfunction

  function automatic void rank_update(logic [KEY_W-1:0] k, logic [COUNT_BITS-1:0] c);
    if (lead_cnt != 0 && k == lead_key) begin
      lead_cnt = c;
    end else if (c > lead_cnt) begin
      // promote, old leader drops to second (also when k was second)
      second_key = lead_key;
      second_cnt = lead_cnt;
      lead_key   = k;
      lead_cnt   = c;
    end else if (second_cnt != 0 && k == second_key) begin
      second_cnt = c;
    end else if (c > second_cnt) begin
      second_key = k;
      second_cnt = c;
    end
  endfunction

  function automatic void tally_value(logic [KEY_W-1:0] k);
    int slot;
    slot = -1;
    for (int i = 0; i < MAX_DISTINCT; i++) begin
      if (slot < 0 && hist_used[i] && hist_key[i] == k) slot = i;
    end
    if (slot >= 0) begin
      if (hist_cnt[slot] != COUNT_TOP) hist_cnt[slot] = hist_cnt[slot] + 1'b1;
      rank_update(k, hist_cnt[slot]);
      return;
    end
    if (distinct_n >= MAX_DISTINCT) begin
      dropped_key = 1'b1;
      return;
    end
    for (int i = 0; i < MAX_DISTINCT; i++) begin
      if (slot < 0 && !hist_used[i]) slot = i;
    end
    hist_used[slot] = 1'b1;
    hist_key[slot]  = k;
    hist_cnt[slot]  = COUNT_BITS'(1);
    distinct_n++;
    rank_update(k, COUNT_BITS'(1));
  endfunction

  function automatic logic [OUT_W-1:0] clip_count(logic [COUNT_BITS-1:0] v);
    return (64'(v) > 64'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : OUT_W'(v);
  endfunction

  function automatic bit predict_modes(in_item_t it, output out_item_t res);
    res = '0;
    if (it.row_empty) begin
      clear_hist();
      return 1'b1;
    end
    tally_value(KEY_W'(it.sample_value));
    if (!it.row_end) return 1'b0;
    if (distinct_n >= 2) begin
      res.first_mode_count  = clip_count(lead_cnt);
      res.second_mode_count = clip_count(second_cnt);
    end
    res.table_overflow = dropped_key;
    clear_hist();
    return 1'b1;
  endfunction

  task automatic push_item(logic [KEY_W-1:0] v, logic last, logic empty);
    in_item_t it;
    it.sample_value = v;
    it.row_end      = last;
    it.row_empty    = empty;
    pending_q.push_back(it);
    queued_n++;
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(15))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic add_random_row();
    logic [KEY_W-1:0] pool[$];
    logic [KEY_W-1:0] base;
    int kind, psize, len;
    kind = $urandom_range(99);
    if (kind < 4) begin
      // lone empty-row marker with junk in the other fields
      push_item($urandom(), 1'($urandom_range(1)), 1'b1);
    end else if (kind < 7) begin
      // enough distinct keys to fill the table, then spill
      psize = $urandom_range(MAX_DISTINCT + 8, MAX_DISTINCT + 1);
      base  = $urandom();
      for (int i = 0; i < psize; i++) pool.push_back(base + i);
      len = psize + $urandom_range(3);
      for (int j = 0; j < len; j++) begin
        push_item((j < psize) ? pool[j] : pool[$urandom_range(psize - 1)],
                  j == len - 1, 1'b0);
      end
    end else begin
      psize = (kind < 25) ? $urandom_range(20, 1) : $urandom_range(6, 1);
      len   = (kind < 25) ? $urandom_range(30, 1) : $urandom_range(12, 1);
      for (int i = 0; i < psize; i++) pool.push_back(rand_key());
      for (int j = 0; j < len; j++) begin
        // drop in an empty marker now and then, cutting the row short
        if ($urandom_range(99) < 3) push_item($urandom(), 1'($urandom_range(1)), 1'b1);
        push_item(pool[$urandom_range(psize - 1)], j == len - 1, 1'b0);
      end
    end
  endtask

  task automatic drain_all();
    wait (pending_q.size() == 0 && !in_valid);
    wait (mode_expect_q.size() == 0);
    @(negedge clk);
  endtask

  // Driver
  always @(posedge clk) begin
    out_item_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        accepted_n++;
        if (predict_modes(in_data, res)) mode_expect_q.push_back(res);
      end
      if (!in_valid || !in_stall) begin
        if (pending_q.size() > 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
          in_data  <= pending_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
      mismatch_n++;
    end
  endfunction

  // Monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (mode_expect_q.size() == 0) begin
          $display("%0t unexpected result: expected none actual %0d/%0d/%0d", $time,
                   out_data.first_mode_count, out_data.second_mode_count,
                   out_data.table_overflow);
          mismatch_n++;
        end else begin
          mode_want = mode_expect_q.pop_front();
          check_field("first_mode_count", 32'(mode_want.first_mode_count),
                      32'(out_data.first_mode_count));
          check_field("second_mode_count", 32'(mode_want.second_mode_count),
                      32'(out_data.second_mode_count));
          check_field("table_overflow", 32'(mode_want.table_overflow),
                      32'(out_data.table_overflow));
          rows_checked++;
          if (mode_want.table_overflow) overflow_n++;
        end
      end
      out_stall <= !no_gaps && ($urandom_range(99) < IDLE_PCT);
    end
  end

  initial begin
    clear_hist();

    // empty row with every other field set
    push_item(32'h7FFF_FFFF, 1'b1, 1'b1);
    // single distinct value gives zeros
    push_item(32'h8000_0000, 1'b1, 1'b0);
    // two modes, extreme keys
    push_item(32'h0000_0000, 1'b0, 1'b0);
    push_item(32'h0000_0000, 1'b0, 1'b0);
    push_item(32'hFFFF_FFFF, 1'b0, 1'b0);
    push_item(32'h7FFF_FFFF, 1'b1, 1'b0);
    // second overtakes first, then first takes the lead back
    push_item(32'h0000_00A1, 1'b0, 1'b0);
    push_item(32'h0000_00B2, 1'b0, 1'b0);
    push_item(32'h0000_00B2, 1'b0, 1'b0);
    push_item(32'h0000_00A1, 1'b0, 1'b0);
    push_item(32'h0000_00A1, 1'b1, 1'b0);
    // partial row discarded by an empty marker, histogram must be clear after
    push_item(32'h0000_0005, 1'b0, 1'b0);
    push_item(32'h0000_0006, 1'b0, 1'b0);
    push_item(32'h0000_0000, 1'b0, 1'b1);
    push_item(32'h0000_0005, 1'b1, 1'b0);
    // new key beats the current second
    push_item(32'h5555_5555, 1'b0, 1'b0);
    push_item(32'h5555_5555, 1'b0, 1'b0);
    push_item(32'hAAAA_AAAA, 1'b0, 1'b0);
    push_item(32'h3C3C_C3C3, 1'b0, 1'b0);
    push_item(32'h3C3C_C3C3, 1'b1, 1'b0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // hold the sender until every row so far has reported
    drain_all();
    while (queued_n < 690) add_random_row();

    drain_all();
    repeat (20) @(posedge clk);

    $display("Covered %0d input transfers and %0d row results", accepted_n, rows_checked);
    $display("  %0d rows overflowed the table", overflow_n);
    if (mismatch_n == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("timeout with %0d results outstanding", mode_expect_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- row_top_two_mode_counter.f -----
sv/rtmc_pkg.sv
sv/rtmc_ctrl.sv
sv/rtmc_dp.sv
sv/row_top_two_mode_counter.sv
tb/tb_row_top_two_mode_counter.sv
